@@ src/aont_pkg.sv @@
// Package: shared constants and the saturating helper of the AND/OR node network tick unit.
`default_nettype none
package aont_pkg;
    localparam logic [1:0] OP_LINK   = 2'd0;
    localparam logic [1:0] OP_NODE   = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [12:0] ONE_Q12  = 13'd4096;

    function automatic logic [12:0] sat_one(input logic [12:0] v);
        sat_one = (v > ONE_Q12) ? ONE_Q12 : v;
    endfunction
endpackage
`default_nettype wire

@@ src/and_or_node_network_tick_unit.sv @@
// Top level: AND/OR node network with per-frame tick, memory-based sequencer.
// Reset is asynchronous; a sweep then zeroes the output and target memories, and
// input is held off until it ends. An item without end_of_frame leaves the unit idle.
// A tick runs two passes over NODES-INPUT_NODES nodes: a target pass that walks the
// links of each node, then an update pass; after them it emits the results, highest
// node first. Input is blocked until the last transfer.
`default_nettype none
module and_or_node_network_tick_unit
    import aont_pkg::*;
#(
    parameter int NODES        = 256,
    parameter int LINKS        = 4,
    parameter int INPUT_NODES  = 32,
    parameter int OUTPUT_NODES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  node_index,
    input  wire logic [1:0]  link_index,
    input  wire logic [7:0]  source_node,
    input  wire logic signed [15:0] weight_value,
    input  wire logic        invert_flag,
    input  wire logic        kind_flag,
    input  wire logic [12:0] gain_value,
    input  wire logic signed [15:0] bias_value,
    input  wire logic [12:0] sample_value,
    input  wire logic        end_of_frame,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       out_index,
    output logic [12:0]      out_value,
    output logic             out_last
);
    localparam int NW = $clog2(NODES);
    localparam int KW = (LINKS > 1) ? $clog2(LINKS) : 1;
    localparam int LW = $clog2(NODES * LINKS);
    localparam int EMIT = (OUTPUT_NODES < 8) ? OUTPUT_NODES : 8;
    localparam logic [NW-1:0] FIRST = NW'(INPUT_NODES);
    localparam logic [NW-1:0] LASTN = NW'(NODES - 1);
    localparam logic [KW-1:0] LASTK = KW'(LINKS - 1);

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_NRD = 4'd2, S_LRD = 4'd3,
        S_ORD = 4'd4, S_ACC = 4'd5, S_MUL = 4'd6, S_FIN = 4'd7, S_TGT = 4'd8,
        S_URD = 4'd9, S_UM1 = 4'd10, S_UWR = 4'd11, S_ERD = 4'd12, S_EMT = 4'd13;

    logic [3:0] st_reg, st_next;
    logic [NW-1:0] n_reg, n_next;
    logic [KW-1:0] k_reg, k_next;
    logic [2:0] e_reg, e_next;
    logic signed [47:0] s_reg, s_next;
    logic [12:0] p_reg, p_next;
    logic [25:0] m_reg, m_next;
    logic [12:0] oi_reg, oi_next;
    logic ov_reg, ov_next;

    // memories
    logic out_we, tgt_we, lk_we, nd_we;
    logic [NW-1:0] out_wa, out_ra, tgt_wa, tgt_ra, nd_wa, nd_ra;
    logic [12:0] out_wd, out_rd, tgt_wd, tgt_rd;
    logic [LW-1:0] lk_wa, lk_ra;
    logic [24:0] lk_wd, lk_rd;
    logic [29:0] nd_wd, nd_rd;

    aont_ram #(.WIDTH(13), .DEPTH(NODES)) u_out (.clk, .we(out_we), .waddr(out_wa),
        .wdata(out_wd), .raddr(out_ra), .rdata(out_rd));
    aont_ram #(.WIDTH(13), .DEPTH(NODES)) u_tgt (.clk, .we(tgt_we), .waddr(tgt_wa),
        .wdata(tgt_wd), .raddr(tgt_ra), .rdata(tgt_rd));
    aont_ram #(.WIDTH(25), .DEPTH(NODES * LINKS)) u_lnk (.clk, .we(lk_we),
        .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));
    aont_ram #(.WIDTH(30), .DEPTH(NODES)) u_nod (.clk, .we(nd_we), .waddr(nd_wa),
        .wdata(nd_wd), .raddr(nd_ra), .rdata(nd_rd));

    wire accept = in_valid && in_ready;
    wire nd_ok = (32'(node_index) < 32'(NODES));
    wire [7:0] lsrc = lk_rd[24:17];
    wire signed [15:0] lwt = lk_rd[16:1];
    wire linv = lk_rd[0];
    wire nkind = nd_rd[29];
    wire [12:0] ngain = nd_rd[28:16];
    wire signed [15:0] nbias = nd_rd[15:0];
    logic [12:0] v_reg, v_next;
    logic [12:0] g_reg, g_next;
    wire [12:0] lv = ((32'(lsrc) < 32'(NODES)) ? out_rd : 13'd0);

    assign in_ready = (st_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_index = e_reg;
    assign out_value = oi_reg;
    assign out_last = (e_reg == 3'(EMIT - 1));

    logic [12:0] vv;
    logic signed [47:0] tt;
    logic [25:0] upd;
    always_comb
    begin
        st_next = st_reg; n_next = n_reg; k_next = k_reg; e_next = e_reg;
        s_next = s_reg; p_next = p_reg; m_next = m_reg; oi_next = oi_reg;
        ov_next = ov_reg; v_next = v_reg; g_next = g_reg;
        out_we = 1'b0; out_wa = n_reg; out_wd = 13'd0; out_ra = n_reg;
        tgt_we = 1'b0; tgt_wa = n_reg; tgt_wd = 13'd0; tgt_ra = n_reg;
        lk_we = 1'b0; lk_wd = {source_node, weight_value, invert_flag};
        lk_wa = LW'(node_index * LINKS + link_index);
        lk_ra = LW'(n_reg * LINKS + k_reg);
        nd_we = 1'b0; nd_wa = NW'(node_index);
        nd_wd = {kind_flag, sat_one(gain_value), bias_value}; nd_ra = n_reg;
        vv = linv ? (ONE_Q12 - lv) : lv;
        tt = s_reg + 48'sd2048;
        upd = 26'(m_reg + 26'(tgt_rd) * 26'(g_reg) + 26'd2048);
        if (out_valid && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            S_CLR:
            begin
                out_we = 1'b1; tgt_we = 1'b1;
                n_next = n_reg + 1'b1;
                if (n_reg == LASTN)
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_LINK && nd_ok && 32'(link_index) < 32'(LINKS))
                    begin
                        lk_we = 1'b1;
                    end
                    if (op == OP_NODE && nd_ok)
                    begin
                        nd_we = 1'b1;
                    end
                    if (op == OP_SAMPLE && 32'(node_index) < 32'(INPUT_NODES))
                    begin
                        out_we = 1'b1; out_wa = NW'(node_index);
                        out_wd = sat_one(sample_value);
                    end
                    if (end_of_frame)
                    begin
                        n_next = FIRST; st_next = S_NRD;
                    end
                end
            end
            S_NRD:
            begin
                k_next = '0; p_next = ONE_Q12; st_next = S_LRD;
            end
            S_LRD:
            begin
                // node and link words valid next cycle
                st_next = S_ORD;
                if (k_reg == '0)
                begin
                    s_next = '0;
                end
            end
            S_ORD:
            begin
                out_ra = NW'(lsrc);
                if (k_reg == '0)
                begin
                    s_next = nkind ? 48'(signed'(nbias) * 48'sd4096) : '0;
                    g_next = 13'(nkind);
                end
                m_next = 26'(signed'(lwt));
                st_next = S_ACC;
            end
            S_ACC:
            begin
                v_next = vv;
                st_next = S_MUL;
            end
            S_MUL:
            begin
                if (g_reg[0])
                begin
                    s_next = s_reg + 48'(signed'(m_reg[15:0]) * signed'({1'b0, v_reg}));
                end
                else
                begin
                    m_next = 26'(p_reg * v_reg + 26'd2048);
                end
                st_next = S_FIN;
            end
            S_FIN:
            begin
                if (!g_reg[0])
                begin
                    p_next = m_reg[24:12];
                end
                if (k_reg == LASTK)
                begin
                    st_next = S_TGT;
                end
                else
                begin
                    k_next = k_reg + 1'b1; st_next = S_LRD;
                end
            end
            S_TGT:
            begin
                // node word still on nd_rd (address held)
                if (!g_reg[0])
                begin
                    s_next = 48'(signed'({1'b0, p_reg}) * nbias);
                    g_next = 13'b10;
                    st_next = S_TGT;
                end
                if (g_reg[1] || g_reg[0])
                begin
                    tgt_we = 1'b1;
                    tgt_wd = (s_reg <= 0) ? 13'd0 :
                             ((tt[47:12] > 36'd4096) ? ONE_Q12 : tt[24:12]);
                    if (n_reg == LASTN)
                    begin
                        n_next = FIRST; st_next = S_URD;
                    end
                    else
                    begin
                        n_next = n_reg + 1'b1; st_next = S_NRD;
                    end
                end
            end
            S_URD:
            begin
                st_next = S_UM1;
            end
            S_UM1:
            begin
                g_next = ngain;
                m_next = 26'(out_rd * (ONE_Q12 - ngain));
                st_next = S_UWR;
            end
            S_UWR:
            begin
                out_we = 1'b1; out_wd = upd[24:12];
                if (n_reg == LASTN)
                begin
                    e_next = '0; n_next = LASTN; st_next = S_ERD;
                end
                else
                begin
                    n_next = n_reg + 1'b1; st_next = S_URD;
                end
            end
            S_ERD:
            begin
                if (!ov_reg)
                begin
                    st_next = S_EMT;
                end
            end
            S_EMT:
            begin
                oi_next = out_rd; ov_next = 1'b1;
                if (e_reg == 3'(EMIT - 1))
                begin
                    st_next = S_IDLE;
                end
                else
                begin
                    n_next = n_reg - 1'b1; st_next = S_ERD;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
        if (st_reg == S_ERD && ov_reg && out_ready && e_reg != 3'(EMIT - 1))
        begin
            e_next = e_reg + 1'b1;
        end
        if (st_reg == S_IDLE && ov_reg && out_ready)
        begin
            e_next = e_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLR; n_reg <= '0; k_reg <= '0; e_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; n_reg <= n_next; k_reg <= k_next;
            e_reg <= e_next; ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next; p_reg <= p_next; m_reg <= m_next; oi_reg <= oi_next;
        v_reg <= v_next; g_reg <= g_next;
    end
endmodule
`default_nettype wire

@@ src/aont_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module aont_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ tb/aont_checker.sv @@
// Checker: predicts AND/OR network tick results and compares the output transfers.
`timescale 1ns / 1ps
module aont_checker
    import aont_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [1:0]         op,
    input  wire logic [7:0]         node_index,
    input  wire logic [1:0]         link_index,
    input  wire logic [7:0]         source_node,
    input  wire logic signed [15:0] weight_value,
    input  wire logic               invert_flag,
    input  wire logic               kind_flag,
    input  wire logic [12:0]        gain_value,
    input  wire logic signed [15:0] bias_value,
    input  wire logic [12:0]        sample_value,
    input  wire logic               end_of_frame,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [2:0]         out_index,
    input  wire logic [12:0]        out_value,
    input  wire logic               out_last,
    output int                      fail_count,
    output int                      pending_count
);
    localparam int NODE_CNT  = 256;
    localparam int LINK_CNT  = 4;
    localparam int INPUT_CNT = 32;
    localparam int EMIT_CNT  = 8;

    typedef struct packed {
        logic [2:0]  idx;
        logic [12:0] val;
        logic        last;
    } node_result_t;

    node_result_t        result_q[$];
    logic [12:0]         node_out[NODE_CNT];
    logic [12:0]         node_tgt[NODE_CNT];
    logic [7:0]          lnk_src[NODE_CNT*LINK_CNT];
    logic signed [15:0]  lnk_wt[NODE_CNT*LINK_CNT];
    logic                lnk_inv[NODE_CNT*LINK_CNT];
    logic                nd_kind[NODE_CNT];
    logic [12:0]         nd_gain[NODE_CNT];
    logic signed [15:0]  nd_bias[NODE_CNT];

    initial begin
        fail_count = 0;
        pending_count = 0;
        for (int i = 0; i < NODE_CNT; i++) begin
            node_out[i] = '0;
            node_tgt[i] = '0;
        end
    end

    function automatic logic [12:0] clamp_one(input logic [12:0] v);
        return (v > ONE_Q12) ? ONE_Q12 : v;
    endfunction

    function automatic longint link_level(input int n, input int k);
        longint v;
        v = node_out[lnk_src[n*LINK_CNT+k]];
        if (lnk_inv[n*LINK_CNT+k]) v = 4096 - v;
        return v;
    endfunction

    task automatic network_tick();
        longint s, p, t, g, o;
        node_result_t r;
        for (int n = INPUT_CNT; n < NODE_CNT; n++) begin
            if (nd_kind[n] == 1'b0) begin
                p = 4096;
                for (int k = 0; k < LINK_CNT; k++)
                    p = (p * link_level(n, k) + 2048) >>> 12;
                s = p * longint'(nd_bias[n]);
            end else begin
                s = longint'(nd_bias[n]) * 4096;
                for (int k = 0; k < LINK_CNT; k++)
                    s += link_level(n, k) * longint'(lnk_wt[n*LINK_CNT+k]);
            end
            if (s <= 0) t = 0;
            else begin
                t = (s + 2048) >>> 12;
                if (t > 4096) t = 4096;
            end
            node_tgt[n] = t[12:0];
        end
        for (int n = INPUT_CNT; n < NODE_CNT; n++) begin
            g = nd_gain[n];
            o = node_out[n];
            t = node_tgt[n];
            o = (o * (4096 - g) + t * g + 2048) >>> 12;
            node_out[n] = o[12:0];
        end
        for (int i = 0; i < EMIT_CNT; i++) begin
            r.idx  = i[2:0];
            r.val  = node_out[NODE_CNT-1-i];
            r.last = (i == EMIT_CNT - 1);
            result_q = {result_q, r};
        end
    endtask

    always @(posedge clk) begin
        node_result_t e;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected output transfer: idx %0d val %0d last %0d",
                                 out_index, out_value, out_last);
                end else begin
                    e = result_q.pop_front();
                    if (e.idx !== out_index || e.val !== out_value || e.last !== out_last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp idx %0d val %0d last %0d, got %0d %0d %0d",
                                     e.idx, e.val, e.last, out_index, out_value, out_last);
                    end
                end
            end
            if (in_valid && in_ready) begin
                case (op)
                    OP_LINK: begin
                        lnk_src[node_index*LINK_CNT+link_index] = source_node;
                        lnk_wt[node_index*LINK_CNT+link_index]  = weight_value;
                        lnk_inv[node_index*LINK_CNT+link_index] = invert_flag;
                    end
                    OP_NODE: begin
                        nd_kind[node_index] = kind_flag;
                        nd_gain[node_index] = clamp_one(gain_value);
                        nd_bias[node_index] = bias_value;
                    end
                    OP_SAMPLE:
                        if (node_index < INPUT_CNT)
                            node_out[node_index] = clamp_one(sample_value);
                    default: ;
                endcase
                if (end_of_frame) network_tick();
            end
        end
        pending_count = result_q.size();
    end
endmodule

@@ tb/testbench.sv @@
// Testbench top: stimulus, flow control and verdict for the AND/OR node network tick unit.
`timescale 1ns / 1ps
module testbench
    import aont_pkg::*;
();

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 40000000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic [7:0]         node_index;
    logic [1:0]         link_index;
    logic [7:0]         source_node;
    logic signed [15:0] weight_value;
    logic               invert_flag;
    logic               kind_flag;
    logic [12:0]        gain_value;
    logic signed [15:0] bias_value;
    logic [12:0]        sample_value;
    logic               end_of_frame;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         out_index;
    logic [12:0]        out_value;
    logic               out_last;
    int                 fail_count;
    int                 pending_count;
    int                 cycle_count;
    bit                 steady_send;

    and_or_node_network_tick_unit dut (.*);

    aont_checker checker_i (.*);

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("and_or_node_network_tick_unit test failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off, a clean stretch, then random stalls again
    initial begin
        int c;
        c = 0;
        forever begin
            @(posedge clk);
            c++;
            if (c >= 30000 && c < 40000) out_ready <= 1'b0;
            else if (c >= 40000 && c < 46000) out_ready <= 1'b1;
            else out_ready <= ($urandom_range(99) >= 30);
        end
    end

    task automatic send_item(input logic [1:0] o, input logic [7:0] n, input logic [1:0] l,
                             input logic [7:0] src, input logic [15:0] w, input logic inv,
                             input logic kd, input logic [12:0] g, input logic [15:0] b,
                             input logic [12:0] smp, input logic eof);
        if (!steady_send && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= o;
        node_index   <= n;
        link_index   <= l;
        source_node  <= src;
        weight_value <= w;
        invert_flag  <= inv;
        kind_flag    <= kd;
        gain_value   <= g;
        bias_value   <= b;
        sample_value <= smp;
        end_of_frame <= eof;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_random(input logic [1:0] o, input logic [7:0] n, input logic eof);
        logic [15:0] w;
        w = ($urandom_range(1) == 1) ? 16'($urandom) : 16'($urandom_range(12000) - 6000);
        send_item(o, n, 2'($urandom), 8'($urandom), w, 1'($urandom), 1'($urandom),
                  ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(4096)),
                  ($urandom_range(1) == 1) ? 16'($urandom) : 16'($urandom_range(8192)),
                  ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(4096)),
                  eof);
    endtask

    initial begin
        int r;
        logic [1:0] o;
        logic [7:0] n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cycle_count = 0;
        steady_send = 1'b0;
        {op, node_index, link_index, source_node, weight_value, invert_flag, kind_flag,
         gain_value, bias_value, sample_value, end_of_frame} = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // define every link and node the tick reads
        for (int nd = 32; nd < 256; nd++) begin
            for (int k = 0; k < 4; k++)
                send_item(OP_LINK, 8'(nd), 2'(k), 8'($urandom),
                          ($urandom_range(1) == 1) ? 16'($urandom)
                                                   : 16'($urandom_range(12000) - 6000),
                          1'($urandom), 1'b0, '0, '0, '0, 1'b0);
            send_item(OP_NODE, 8'(nd), '0, '0, '0, 1'b0, 1'($urandom),
                      13'($urandom_range(4096)), 16'($urandom_range(8192)), '0, 1'b0);
        end

        // directed corners
        send_item(OP_SAMPLE, 8'd0, '0, '0, '0, 1'b0, 1'b0, '0, '0, 13'd0, 1'b0);
        send_item(OP_SAMPLE, 8'd31, '0, '0, '0, 1'b0, 1'b0, '0, '0, 13'h1fff, 1'b0);
        send_item(OP_SAMPLE, 8'd5, '0, '0, '0, 1'b0, 1'b0, '0, '0, 13'd4096, 1'b1);
        send_item(OP_SAMPLE, 8'd32, '0, '0, '0, 1'b0, 1'b0, '0, '0, 13'd4000, 1'b0);
        send_item(OP_SAMPLE, 8'd255, '0, '0, '0, 1'b0, 1'b0, '0, '0, 13'd4096, 1'b0);
        send_item(OP_LINK, 8'd255, 2'd0, 8'd0, 16'sh7fff, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        send_item(OP_LINK, 8'd255, 2'd3, 8'd255, 16'sh8000, 1'b1, 1'b0, '0, '0, '0, 1'b0);
        send_item(OP_LINK, 8'd0, 2'd1, 8'd200, 16'sh1000, 1'b1, 1'b0, '0, '0, '0, 1'b0);
        send_item(OP_NODE, 8'd255, '0, '0, '0, 1'b0, 1'b1, 13'h1fff, 16'sh7fff, '0, 1'b0);
        send_item(OP_NODE, 8'd254, '0, '0, '0, 1'b0, 1'b0, 13'd4096, 16'sh8000, '0, 1'b0);
        send_item(OP_NODE, 8'd253, '0, '0, '0, 1'b0, 1'b0, 13'd0, 16'sh1000, '0, 1'b0);
        send_item(OP_NODE, 8'd10, '0, '0, '0, 1'b0, 1'b1, 13'd100, 16'sh0100, '0, 1'b0);
        send_item(OP_LINK, 8'd250, 2'd2, 8'd31, 16'sh0800, 1'b0, 1'b0, '0, '0, '0, 1'b1);
        send_item(OP_NODE, 8'd249, '0, '0, '0, 1'b0, 1'b1, 13'd4096, 16'sh0000, '0, 1'b1);
        send_item(OP_NONE, 8'd7, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        send_item(OP_NONE, 8'hff, 2'd3, 8'hff, 16'hffff, 1'b1, 1'b1, 13'h1fff, 16'hffff,
                  13'h1fff, 1'b1);
        send_item(OP_SAMPLE, 8'd31, '0, '0, '0, 1'b0, 1'b0, '0, '0, 13'd0, 1'b1);

        // random traffic
        for (int i = 0; i < 310; i++) begin
            if (i == 150) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_count != 0) @(posedge clk);
            end
            steady_send = (i >= 200 && i < 260);
            r = $urandom_range(99);
            o = (r < 50) ? OP_SAMPLE : (r < 70) ? OP_LINK : (r < 90) ? OP_NODE : OP_NONE;
            n = 8'($urandom);
            if (o == OP_SAMPLE && $urandom_range(99) < 80) n = 8'($urandom_range(31));
            send_random(o, n, $urandom_range(7) == 0);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("and_or_node_network_tick_unit test passed");
        else
            $display("and_or_node_network_tick_unit test failed");
        $finish;
    end
endmodule

@@ sim.f @@
src/aont_pkg.sv
src/aont_ram.sv
src/and_or_node_network_tick_unit.sv
tb/aont_checker.sv
tb/testbench.sv
